>>> design/bals_pkg.sv
// shared types and constants of the battery average and led status unit
package bals_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int THR_W      = 12;
    localparam int PERIOD_W   = 16;
    localparam int CFG_DATA_W = 16;
    localparam int DATA_W     = 16;
    localparam int PHASE_W    = 7;
    localparam int TENTH_W    = 4;
    localparam int BURST_W    = 3;

    localparam logic [PHASE_W-1:0] PHASE_LAST = 7'd99;
    localparam logic [PHASE_W-1:0] PHASE_HALF = 7'd50;
    localparam logic [TENTH_W-1:0] TENTH_LAST = 4'd9;
    localparam logic [BURST_W-1:0] BURST_LEN  = 3'd4;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET    = 16'd10;
    localparam logic [THR_W-1:0]    THRESHOLD_RESET = 12'd2000;

    // configuration register indexes
    localparam logic CFG_PROBE_PERIOD  = 1'b0;
    localparam logic CFG_LOW_THRESHOLD = 1'b1;

    // link state codes
    localparam logic [1:0] LINK_CONNECTING = 2'd0;
    localparam logic [1:0] LINK_BOOT       = 2'd1;
    localparam logic [1:0] LINK_CONNECTED  = 2'd2;
    localparam logic [1:0] LINK_LOST       = 2'd3;

    typedef enum logic [1:0] {
        MODE_LOW_BATT  = 2'd0,
        MODE_NOT_CONN  = 2'd1,
        MODE_CONNECTED = 2'd2,
        MODE_BOOT      = 2'd3
    } led_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SUB,
        ST_ADD,
        ST_DIV,
        ST_LED
    } bals_state_t;

    typedef enum logic [1:0] {
        ALU_EVICT,
        ALU_SAMPLE,
        ALU_DIV
    } alu_op_t;

endpackage

>>> design/battery_average_led_status_unit.sv
// battery sample window average, low battery test and status led sequencer
//
//  channel   ports          word layout (lsb first)
//  input     s_t*           battery_sample[11:0], link_state[13:12], zero pad
//  result    m_t*           led_level[0], led_mode[2:1], battery_average[14:3], zero
//  config    cfg_*          index 0 probe_period, index 1 low_threshold
//
//  a tick that takes no probe goes from IDLE straight to LED and back to IDLE
//  a probe tick steps through READ, SUB, ADD, DIV and LED; DIV is the
//  restoring divide that runs one quotient bit per cycle on the shared adder
//  aresetn is synchronous active low and clears all control state at once
//  one result register parts the sides: a new word is taken while a result
//  waits, and the sequencer waits in its last step only when that register is full
module battery_average_led_status_unit
    import bals_pkg::*;
#(
    parameter int WINDOW = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [DATA_W-1:0]     s_tdata,    // battery_sample[11:0], link_state[13:12]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [DATA_W-1:0]     m_tdata,    // led_level[0], led_mode[2:1], average[14:3]
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);
    localparam int STEP_W = $clog2(SUM_W);

    bals_state_t state_reg, state_next;

    logic [PERIOD_W-1:0] period_reg;
    logic [THR_W-1:0]    thr_reg;
    logic [PHASE_W-1:0]  phase_reg;
    logic [TENTH_W-1:0]  tenth_reg;
    logic [PERIOD_W-1:0] probe_cnt_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [CNT_W-1:0]    fill_cnt_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SAMPLE_W-1:0] avg_reg;
    logic                burst_active_reg;
    logic [BURST_W-1:0]  burst_tog_reg;
    logic                led_reg;

    logic [SAMPLE_W-1:0] sample_reg;
    logic [1:0]          link_reg;
    logic [SAMPLE_W-1:0] evict_reg;
    logic                evict_valid_reg;
    logic [SUM_W-1:0]    quo_reg;
    logic [CNT_W-1:0]    rem_reg;
    logic [STEP_W-1:0]   step_reg;

    logic                out_valid_reg;
    logic                out_level_reg;
    led_mode_t           out_mode_reg;
    logic [SAMPLE_W-1:0] out_avg_reg;

    logic [SAMPLE_W-1:0] win_mem [WINDOW];

    // sequencer outputs
    logic    in_ready;
    logic    mem_en;
    alu_op_t alu_op;

    // shared add / subtract unit
    logic [SUM_W:0] alu_a, alu_b, alu_y;
    logic           alu_sub;

    logic [PERIOD_W:0] probe_inc;
    logic              probe_hit;
    logic              in_take;
    logic              out_free;

    logic [CNT_W:0]    div_shift;
    logic              div_fit;
    logic [SUM_W-1:0]  quo_step;
    logic [CNT_W-1:0]  rem_step;

    led_mode_t          mode;
    logic               tick10, tick50;
    logic [BURST_W-1:0] tog_inc;
    logic               led_next;
    logic               burst_active_next;
    logic [BURST_W-1:0] burst_tog_next;

    assign in_take  = s_tvalid && in_ready;
    assign out_free = !out_valid_reg || m_tready;

    assign probe_inc = {1'b0, probe_cnt_reg} + {{PERIOD_W{1'b0}}, 1'b1};
    assign probe_hit = probe_inc >= {1'b0, period_reg};

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = probe_hit ? ST_READ : ST_LED;
                end
            end
            ST_READ: state_next = ST_SUB;
            ST_SUB:  state_next = ST_ADD;
            ST_ADD:  state_next = ST_DIV;
            ST_DIV: begin
                if (step_reg == STEP_W'(SUM_W - 1)) begin
                    state_next = ST_LED;
                end
            end
            ST_LED: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        in_ready = 1'b0;
        mem_en   = 1'b0;
        alu_op   = ALU_DIV;
        unique case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_READ: mem_en = 1'b1;
            ST_SUB:  alu_op = ALU_EVICT;
            ST_ADD:  alu_op = ALU_SAMPLE;
            ST_DIV:  alu_op = ALU_DIV;
            ST_LED:  alu_op = ALU_DIV;
            default: in_ready = 1'b0;
        endcase
    end

    assign div_shift = {rem_reg, quo_reg[SUM_W-1]};

    always_comb begin
        alu_a   = {1'b0, sum_reg};
        alu_b   = '0;
        alu_sub = 1'b1;
        unique case (alu_op)
            ALU_EVICT: begin
                alu_b = evict_valid_reg ? (SUM_W+1)'(evict_reg) : '0;
            end
            ALU_SAMPLE: begin
                alu_b   = (SUM_W+1)'(sample_reg);
                alu_sub = 1'b0;
            end
            ALU_DIV: begin
                alu_a = (SUM_W+1)'(div_shift);
                alu_b = (SUM_W+1)'(fill_cnt_reg);
            end
            default: alu_b = '0;
        endcase
        alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    end

    // one restoring divide step: no borrow means the divisor fits
    assign div_fit  = !alu_y[SUM_W];
    assign quo_step = {quo_reg[SUM_W-2:0], div_fit};
    assign rem_step = div_fit ? alu_y[CNT_W-1:0] : div_shift[CNT_W-1:0];

    // led mode and drive for this tick
    assign tick10  = (tenth_reg == '0);
    assign tick50  = (phase_reg == '0) || (phase_reg == PHASE_HALF);
    assign tog_inc = burst_tog_reg + BURST_W'(1);

    always_comb begin
        if (avg_reg < thr_reg) begin
            mode = MODE_LOW_BATT;
        end else begin
            unique case (link_reg) inside
                LINK_BOOT:                  mode = MODE_BOOT;
                LINK_CONNECTED:             mode = MODE_CONNECTED;
                LINK_CONNECTING, LINK_LOST: mode = MODE_NOT_CONN;
                default:                    mode = MODE_NOT_CONN;
            endcase
        end
    end

    always_comb begin
        led_next          = led_reg;
        burst_active_next = burst_active_reg;
        burst_tog_next    = burst_tog_reg;
        unique case (mode)
            MODE_LOW_BATT: begin
                if (tick10) begin
                    led_next = !led_reg;
                end
            end
            MODE_NOT_CONN: begin
                if (tick50) begin
                    led_next = !led_reg;
                end
            end
            MODE_CONNECTED: led_next = 1'b0;
            MODE_BOOT: begin
                if (burst_active_reg) begin
                    if (tick10) begin
                        led_next       = !led_reg;
                        burst_tog_next = tog_inc;
                    end
                    if (burst_tog_next >= BURST_LEN) begin
                        burst_active_next = 1'b0;
                        burst_tog_next    = '0;
                    end
                end else begin
                    led_next = 1'b0;
                    if (phase_reg == '0) begin
                        burst_active_next = 1'b1;
                    end
                end
            end
            default: led_next = led_reg;
        endcase
    end

    // sample ring: the evicted entry is read as the new one is written
    always_ff @(posedge aclk) begin
        if (mem_en) begin
            evict_reg         <= win_mem[slot_reg];
            win_mem[slot_reg] <= sample_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            period_reg       <= PERIOD_RESET;
            thr_reg          <= THRESHOLD_RESET;
            phase_reg        <= '0;
            tenth_reg        <= '0;
            probe_cnt_reg    <= '0;
            slot_reg         <= '0;
            fill_cnt_reg     <= '0;
            sum_reg          <= '0;
            avg_reg          <= '0;
            burst_active_reg <= 1'b0;
            burst_tog_reg    <= '0;
            led_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_PROBE_PERIOD:  period_reg <= cfg_wdata[PERIOD_W-1:0];
                    CFG_LOW_THRESHOLD: thr_reg    <= cfg_wdata[THR_W-1:0];
                    default:           thr_reg    <= thr_reg;
                endcase
            end

            if (in_take) begin
                phase_reg     <= (phase_reg == PHASE_LAST) ? '0 : phase_reg + PHASE_W'(1);
                tenth_reg     <= (tenth_reg == TENTH_LAST) ? '0 : tenth_reg + TENTH_W'(1);
                probe_cnt_reg <= probe_hit ? '0 : probe_inc[PERIOD_W-1:0];
            end

            if (state_reg == ST_READ) begin
                slot_reg <= (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + SLOT_W'(1);
                if (fill_cnt_reg != CNT_W'(WINDOW)) begin
                    fill_cnt_reg <= fill_cnt_reg + CNT_W'(1);
                end
            end

            if (state_reg == ST_SUB || state_reg == ST_ADD) begin
                sum_reg <= alu_y[SUM_W-1:0];
            end

            if (state_reg == ST_DIV && step_reg == STEP_W'(SUM_W - 1)) begin
                avg_reg <= quo_step[SAMPLE_W-1:0];
            end

            if (state_reg == ST_LED && out_free) begin
                led_reg          <= led_next;
                burst_active_reg <= burst_active_next;
                burst_tog_reg    <= burst_tog_next;
                out_valid_reg    <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload and datapath work registers
    always_ff @(posedge aclk) begin
        if (in_take) begin
            sample_reg <= s_tdata[SAMPLE_W-1:0];
            link_reg   <= s_tdata[SAMPLE_W+1:SAMPLE_W];
        end
        if (state_reg == ST_READ) begin
            evict_valid_reg <= (fill_cnt_reg == CNT_W'(WINDOW));
        end
        if (state_reg == ST_ADD) begin
            quo_reg  <= alu_y[SUM_W-1:0];
            rem_reg  <= '0;
            step_reg <= '0;
        end
        if (state_reg == ST_DIV) begin
            quo_reg  <= quo_step;
            rem_reg  <= rem_step;
            step_reg <= step_reg + STEP_W'(1);
        end
        if (state_reg == ST_LED && out_free) begin
            out_level_reg <= led_next;
            out_mode_reg  <= mode;
            out_avg_reg   <= avg_reg;
        end
    end

    assign s_tready = in_ready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(DATA_W - SAMPLE_W - 3){1'b0}}, out_avg_reg, out_mode_reg, out_level_reg};

endmodule

>>> design/bals_checker.sv
// port level checks for the battery average and led status unit
module bals_checker
    import bals_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic [DATA_W-1:0] s_tdata,   // battery_sample[11:0], link_state[13:12]
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata    // led_level[0], led_mode[2:1], average[14:3]
);

    // a stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // one tick at a time: the input side closes right after a word is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while previous tick still at work");

    // connected mode always drives the led off
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (led_mode_t'(m_tdata[2:1]) == MODE_CONNECTED) |-> !m_tdata[0])
        else $error("led on in connected mode");

    // pad bit of the result word stays zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[DATA_W-1] == 1'b0))
        else $error("result pad bit set");

endmodule

bind battery_average_led_status_unit bals_checker u_bals_checker (.*);

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench for the battery average and led status unit
module tb_top;
    import bals_pkg::*;

    localparam int WIN          = 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS  = 10;
    localparam int PHASE_TICKS  = 62;

    // same bit order as the result word, led_level in bit 0
    typedef struct packed {
        logic [SAMPLE_W-1:0] average;
        led_mode_t           mode;
        logic                level;
    } led_status_t;

    class led_status_tracker;
        logic [PERIOD_W-1:0] period;
        logic [THR_W-1:0]    threshold;
        logic [PHASE_W-1:0]  phase;
        logic [16:0]         probe_cnt;
        logic [SAMPLE_W-1:0] ring [WIN];
        logic [3:0]          slot;
        logic [4:0]          fill;
        logic [15:0]         sum;
        logic [SAMPLE_W-1:0] average;
        logic                burst_on;
        logic [BURST_W-1:0]  toggles;
        logic                led;
        led_status_t         status_due [$];
        int                  mismatches;

        function new();
            period     = PERIOD_RESET;
            threshold  = THRESHOLD_RESET;
            phase      = '0;
            probe_cnt  = '0;
            foreach (ring[i]) ring[i] = '0;
            slot       = '0;
            fill       = '0;
            sum        = '0;
            average    = '0;
            burst_on   = 1'b0;
            toggles    = '0;
            led        = 1'b0;
            mismatches = 0;
        endfunction

        function void set_register(logic idx, logic [CFG_DATA_W-1:0] value);
            if (idx == CFG_PROBE_PERIOD)
                period = value[PERIOD_W-1:0];
            else
                threshold = value[THR_W-1:0];
        endfunction

        function void note_tick(logic [SAMPLE_W-1:0] smp, logic [1:0] link);
            logic [SAMPLE_W-1:0] evicted;
            logic [15:0]         quot;
            led_status_t         st;
            phase     = (phase == PHASE_LAST) ? '0 : phase + PHASE_W'(1);
            probe_cnt = probe_cnt + 17'd1;
            // a period of zero probes on every tick
            if (probe_cnt >= {1'b0, period}) begin
                probe_cnt  = '0;
                evicted    = ring[slot];
                ring[slot] = smp;
                sum        = sum + 16'(smp) - 16'(evicted);
                slot       = slot + 4'd1;
                if (fill < 5'(WIN))
                    fill = fill + 5'd1;
                quot    = sum / 16'(fill);
                average = quot[SAMPLE_W-1:0];
            end
            if (average < threshold)
                st.mode = MODE_LOW_BATT;
            else if (link == LINK_BOOT)
                st.mode = MODE_BOOT;
            else if (link == LINK_CONNECTED)
                st.mode = MODE_CONNECTED;
            else
                st.mode = MODE_NOT_CONN;
            case (st.mode)
                MODE_LOW_BATT: begin
                    if (phase % 10 == 0)
                        led = !led;
                end
                MODE_NOT_CONN: begin
                    if (phase % 50 == 0)
                        led = !led;
                end
                MODE_CONNECTED: begin
                    led = 1'b0;
                end
                default: begin
                    // burst progress survives other modes
                    if (burst_on) begin
                        if (phase % 10 == 0) begin
                            led     = !led;
                            toggles = toggles + BURST_W'(1);
                        end
                        if (toggles >= BURST_LEN) begin
                            burst_on = 1'b0;
                            toggles  = '0;
                        end
                    end else begin
                        led = 1'b0;
                        if (phase == 0)
                            burst_on = 1'b1;
                    end
                end
            endcase
            st.level   = led;
            st.average = average;
            status_due = {status_due, st};
        endfunction

        function void check_status(logic [DATA_W-1:0] word);
            led_status_t want;
            led_status_t got;
            got = led_status_t'(word[14:0]);
            if (status_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result word %h with no tick pending", word);
                return;
            end
            want = status_due.pop_front();
            if (got.level !== want.level || got.mode !== want.mode ||
                got.average !== want.average || word[15] !== 1'b0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("mismatch at %0t: expected led %0d mode %0d average %0d pad 0",
                             $realtime, want.level, want.mode, want.average);
                    $display("    got led %0d mode %0d average %0d pad %0d",
                             got.level, got.mode, got.average, word[15]);
                end
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata;     // battery_sample[11:0], link_state[13:12]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [DATA_W-1:0]     m_tdata;     // led_level[0], led_mode[2:1], average[14:3]
    logic                  cfg_we;
    logic                  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    led_status_tracker board;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;
    int cycle_count;

    battery_average_led_status_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // result side: random stalls plus one long hold-off
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_status(m_tdata);
    end

    task automatic send_tick(input logic [SAMPLE_W-1:0] smp, input logic [1:0] link);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(DATA_W-SAMPLE_W-2){1'b0}}, link, smp};
        do @(posedge aclk); while (!s_tready);
        board.note_tick(smp, link);
        @(negedge aclk);
    endtask

    // drop valid, let every result drain and the sequencer go idle
    task automatic settle();
        s_tvalid <= 1'b0;
        while (board.status_due.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
        board.set_register(idx, value);
    endtask

    // runs of one link state around one battery level, with some stray ticks
    task automatic run_ticks(input int count);
        int         run_left;
        int         level;
        int         spread;
        int         value;
        logic [1:0] link;
        run_left = 0;
        level    = 0;
        spread   = 0;
        link     = LINK_BOOT;
        repeat (count) begin
            if (run_left == 0) begin
                run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8)
                                                       : $urandom_range(20, 120);
                case ($urandom_range(0, 5))
                    0: link = LINK_CONNECTING;
                    1: link = LINK_LOST;
                    2: link = LINK_CONNECTED;
                    default: link = LINK_BOOT;
                endcase
                case ($urandom_range(0, 3))
                    0: level = $urandom_range(0, 4095);
                    1: level = int'(board.threshold) + int'($urandom_range(0, 200)) - 100;
                    default: level = $urandom_range(int'(board.threshold), 4095);
                endcase
                spread = $urandom_range(0, 64);
            end
            run_left--;
            if ($urandom_range(0, 9) == 0) begin
                send_tick(SAMPLE_W'($urandom_range(0, 4095)), 2'($urandom_range(0, 3)));
            end else begin
                value = level + int'($urandom_range(0, 2 * spread)) - spread;
                if (value < 0)
                    value = 0;
                else if (value > 4095)
                    value = 4095;
                send_tick(SAMPLE_W'(value), link);
            end
        end
    endtask

    initial begin
        int per;
        int thr;
        board          = new();
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_PROBE_PERIOD;
        cfg_wdata      = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings, average still zero so low battery until the tenth tick
        send_tick(12'h000, LINK_CONNECTING);
        send_tick(12'hFFF, LINK_BOOT);
        send_tick(12'hAAA, LINK_CONNECTED);
        send_tick(12'h555, LINK_LOST);
        repeat (6) send_tick(12'hFFF, LINK_CONNECTED);

        settle();
        write_reg(CFG_PROBE_PERIOD, 16'd1);
        write_reg(CFG_LOW_THRESHOLD, 16'd0);
        send_tick(12'hFFF, LINK_BOOT);
        send_tick(12'h000, LINK_CONNECTED);
        send_tick(12'hFFF, LINK_CONNECTING);
        send_tick(12'h000, LINK_LOST);

        settle();
        write_reg(CFG_PROBE_PERIOD, 16'd0);
        write_reg(CFG_LOW_THRESHOLD, 16'hFFF);
        repeat (4) send_tick(12'hFFF, LINK_BOOT);

        // long period, then lowered below the running count
        settle();
        write_reg(CFG_PROBE_PERIOD, 16'hFFFF);
        repeat (3) send_tick(12'h7FF, LINK_CONNECTED);
        settle();
        write_reg(CFG_PROBE_PERIOD, 16'd2);
        repeat (2) send_tick(12'h800, LINK_CONNECTED);

        for (int ph = 0; ph < 8; ph++) begin
            settle();
            case (ph)
                0: begin per = 1;                     thr = 0;                         end
                1: begin per = 3;                     thr = 2000;                      end
                2: begin per = 0;                     thr = 4095;                      end
                3: begin per = 2;                     thr = $urandom_range(0, 65535);  end
                4: begin per = 1;                     thr = 1000;                      end
                5: begin per = 65535;                 thr = 0;                         end
                6: begin per = $urandom_range(1, 12); thr = $urandom_range(0, 4095);   end
                default: begin per = 10;              thr = 2500;                      end
            endcase
            write_reg(CFG_PROBE_PERIOD, CFG_DATA_W'(per));
            write_reg(CFG_LOW_THRESHOLD, CFG_DATA_W'(thr));
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            // back up the result side so the input stalls
            if (ph == 4)
                hold_cycles = 400;
            run_ticks(PHASE_TICKS);
        end

        settle();
        if (board.mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
